@@ src/bdtc_pkg.sv @@
// Shared types, button codes and helpers for the button debounce transport control.
// No dependencies; every other file uses this package through scoped names.
`timescale 1ns / 1ps

package bdtc_pkg;

    localparam int MAX_TRACKS = 32;

    localparam logic [3:0] NONE_PRESSED = 4'd15;
    localparam logic [3:0] CODE_PLAY    = 4'd13;
    localparam logic [3:0] CODE_STOP    = 4'd11;
    localparam logic [3:0] CODE_NEXT    = 4'd14;
    localparam logic [3:0] CODE_PREV    = 4'd7;

    localparam logic [1:0] CFG_TRACK_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd1;

    localparam logic [5:0] TRACK_COUNT_RESET    = 6'd1;
    localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd20;

    // Index range of a five-bit track index, clamped with the playlist limit.
    localparam int BOUND_MAX = (MAX_TRACKS < 32) ? MAX_TRACKS : 32;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PRESS   = 3'b010,
        PH_RELEASE = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_PLAY = 3'd1,
        ACT_STOP = 3'd2,
        ACT_NEXT = 3'd3,
        ACT_PREV = 3'd4
    } t_action;

    typedef struct packed {
        logic [5:0] track_count;
        logic [7:0] debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic       playing;
        logic       stopped;
        logic [4:0] track_index;
        logic       seek_pulse;
        logic       display_pulse;
        logic       busy_res;
    } t_result;

    function automatic t_action code_to_action(input logic [3:0] code);
        t_action act;
        act = ACT_NONE;
        if (code == CODE_PLAY) act = ACT_PLAY;
        else if (code == CODE_STOP) act = ACT_STOP;
        else if (code == CODE_NEXT) act = ACT_NEXT;
        else if (code == CODE_PREV) act = ACT_PREV;
        return act;
    endfunction

    function automatic logic [5:0] wrap_bound(input logic [5:0] tc);
        logic [5:0] b;
        b = tc;
        if (b < 6'd1) b = 6'd1;
        if (b > 6'(BOUND_MAX)) b = 6'(BOUND_MAX);
        return b;
    endfunction

endpackage

@@ src/bdtc_cfg_regs.sv @@
// Configuration register file: track count and debounce length.
// Depends on bdtc_pkg.
`timescale 1ns / 1ps

module bdtc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [1:0]        i_index,
    input  logic [7:0]        i_data,
    output bdtc_pkg::t_cfg    o_cfg
);

    logic [5:0] r_track_count;
    logic [7:0] r_debounce_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count    <= bdtc_pkg::TRACK_COUNT_RESET;
            r_debounce_ticks <= bdtc_pkg::DEBOUNCE_TICKS_RESET;
        end else if (i_we) begin
            case (i_index)
                bdtc_pkg::CFG_TRACK_COUNT:    r_track_count    <= i_data[5:0];
                bdtc_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.track_count    = r_track_count;
    assign o_cfg.debounce_ticks = r_debounce_ticks;

endmodule

@@ src/bdtc_ctrl.sv @@
// Debounce phase machine and transport state; computes one tick's result.
// Depends on bdtc_pkg.
`timescale 1ns / 1ps

module bdtc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [3:0]        i_sample,
    input  bdtc_pkg::t_cfg    i_cfg,
    output bdtc_pkg::t_result o_result
);

    bdtc_pkg::t_phase  r_phase,  n_phase;
    bdtc_pkg::t_action r_action, n_action;
    logic [7:0]        r_count,  n_count;
    logic              r_play,   n_play;
    logic              r_stop,   n_stop;
    logic [4:0]        r_index,  n_index;

    logic       pressed;
    logic       seek;
    logic       disp;
    logic [5:0] bound;
    logic [5:0] index_inc;

    assign pressed   = (i_sample != bdtc_pkg::NONE_PRESSED);
    assign bound     = bdtc_pkg::wrap_bound(i_cfg.track_count);
    assign index_inc = {1'b0, r_index} + 6'd1;

    always_comb begin
        n_phase  = r_phase;
        n_action = r_action;
        n_count  = r_count;
        n_play   = r_play;
        n_stop   = r_stop;
        n_index  = r_index;
        seek     = 1'b0;
        disp     = 1'b0;
        case (r_phase)
            bdtc_pkg::PH_PRESS: begin
                if (!pressed) begin
                    n_count = '0;
                end else if (r_count < i_cfg.debounce_ticks) begin
                    n_count = r_count + 8'd1;
                end else begin
                    n_count  = '0;
                    n_action = bdtc_pkg::code_to_action(i_sample);
                    n_phase  = bdtc_pkg::PH_RELEASE;
                end
            end
            bdtc_pkg::PH_RELEASE: begin
                if (pressed) begin
                    n_count = '0;
                end else if (r_count < i_cfg.debounce_ticks) begin
                    n_count = r_count + 8'd1;
                end else begin
                    case (r_action)
                        bdtc_pkg::ACT_PLAY: begin
                            if (r_play) begin
                                n_play = 1'b0;
                            end else begin
                                n_play = 1'b1;
                                n_stop = 1'b0;
                            end
                        end
                        bdtc_pkg::ACT_STOP: n_stop = 1'b1;
                        bdtc_pkg::ACT_NEXT: begin
                            seek    = 1'b1;
                            n_index = (index_inc >= bound) ? 5'd0 : index_inc[4:0];
                        end
                        bdtc_pkg::ACT_PREV: begin
                            seek    = 1'b1;
                            n_index = (r_index == 5'd0) ? 5'(bound - 6'd1)
                                                        : r_index - 5'd1;
                        end
                        default: ;
                    endcase
                    n_action = bdtc_pkg::ACT_NONE;
                    n_count  = '0;
                    disp     = 1'b1;
                    n_phase  = bdtc_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = bdtc_pkg::PH_IDLE;
                if (pressed) begin
                    n_phase = bdtc_pkg::PH_PRESS;
                    n_count = '0;
                end
            end
        endcase
    end

    // Advance state only when the tick's word moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bdtc_pkg::PH_IDLE;
            r_action <= bdtc_pkg::ACT_NONE;
            r_count  <= '0;
            r_play   <= 1'b0;
            r_stop   <= 1'b1;
            r_index  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_action <= n_action;
            r_count  <= n_count;
            r_play   <= n_play;
            r_stop   <= n_stop;
            r_index  <= n_index;
        end
    end

    assign o_result.playing       = n_play;
    assign o_result.stopped       = n_stop;
    assign o_result.track_index   = n_index;
    assign o_result.seek_pulse    = seek;
    assign o_result.display_pulse = disp;
    assign o_result.busy_res      = (n_phase != bdtc_pkg::PH_IDLE);

endmodule

@@ src/button_debounce_transport_control_unit.sv @@
// Top level of the button debounce transport control: input and result registers.
// Depends on bdtc_pkg, bdtc_cfg_regs and bdtc_ctrl.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_valid / o_stall with i_button_sample, one debounce tick per
//   word. Output channel: o_valid / i_stall with the six result fields, one
//   word per tick, values after that tick.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   0 = track_count, 1 = debounce_ticks, i_cfg_data holds the value. Write
//   only while no tick is in flight.
//   Path: an accepted sample goes from the input register through the phase
//   update into the result register (one input register, one result register).
//   Throughput: one tick per cycle unless i_stall holds the result word; the
//   phase update is a single short combinational pass from input to result register.
//   Stall: while i_stall holds the result word, the input register still
//   takes one more sample; o_stall rises only when both registers are full.
//   Reset (synchronous, active low): idle phase, count zero, paused,
//   stopped, track 0, track_count 1, debounce_ticks 20, both channels empty.

module button_debounce_transport_control_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_button_sample,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_playing,
    output logic       o_stopped,
    output logic [4:0] o_track_index,
    output logic       o_seek_pulse,
    output logic       o_display_pulse,
    output logic       o_busy_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    bdtc_pkg::t_cfg    cfg;
    bdtc_pkg::t_result step_result;

    logic              r_in_valid;
    logic [3:0]        r_in_sample;
    logic              r_out_valid;
    bdtc_pkg::t_result r_out;

    logic in_accept;
    logic advance;

    assign o_cfg_ready = 1'b1;

    bdtc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bdtc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= i_button_sample;
        end
    end

    // Load a new result word or drop the taken one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_playing       = r_out.playing;
    assign o_stopped       = r_out.stopped;
    assign o_track_index   = r_out.track_index;
    assign o_seek_pulse    = r_out.seek_pulse;
    assign o_display_pulse = r_out.display_pulse;
    assign o_busy_res      = r_out.busy_res;

endmodule
